[rtl/mkdg_pkg.sv]
`default_nettype none
package mkdg_pkg;
  localparam int NREG = 6;
  localparam int MASK_W = 16;
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_MULTI = 3'd1;
  localparam logic [2:0] REG_LONG = 3'd2;
  localparam logic [2:0] REG_REPEAT = 3'd3;
  localparam logic [2:0] REG_LEVEL = 3'd4;
  localparam logic [2:0] REG_ENABLE = 3'd5;
  localparam logic [15:0] DEF_DEBOUNCE = 16'd20;
  localparam logic [15:0] DEF_MULTI = 16'd300;

  typedef enum logic [1:0] {DB_IDLE = 2'd0, DB_DOWN = 2'd1, DB_UP = 2'd2} db_phase_t;
  typedef enum logic [1:0] {
    GS_IDLE = 2'd0, GS_PRESSED = 2'd1, GS_WAIT = 2'd2, GS_LONG = 2'd3
  } gs_phase_t;
  typedef enum logic [2:0] {
    EV_PRESS = 3'd0, EV_RELEASE = 3'd1, EV_CLICK = 3'd2, EV_LONG = 3'd3, EV_CONT = 3'd4
  } ev_code_t;
endpackage
`default_nettype wire

[rtl/mkdg_scan_if.sv]
`default_nettype none
interface mkdg_scan_if;
  logic valid;
  logic ready;
  logic [15:0] raw_levels;
  logic [7:0] elapsed_ticks;
  modport source (output valid, raw_levels, elapsed_ticks, input ready);
  modport sink (input valid, raw_levels, elapsed_ticks, output ready);
endinterface
`default_nettype wire

[rtl/mkdg_event_if.sv]
`default_nettype none
interface mkdg_event_if;
  logic valid;
  logic ready;
  logic [3:0] key_index;
  logic [2:0] event_code;
  logic [7:0] click_total;
  logic key_pressed;
  logic last_event;
  modport source (output valid, key_index, event_code, click_total, key_pressed,
    last_event, input ready);
  modport sink (input valid, key_index, event_code, click_total, key_pressed,
    last_event, output ready);
endinterface
`default_nettype wire

[rtl/mkdg_cfg_if.sv]
`default_nettype none
interface mkdg_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/multi_key_debounce_gesture.sv]
`default_nettype none
// Channel | Dir | Fields
// scan    | in  | raw_levels[15:0], elapsed_ticks[7:0]
// events  | out | key_index, event_code, click_total, key_pressed, last_event
// cfg     | in  | index[2:0], data[15:0]
// A scan first advances time, then walks the keys in turn: a key is read in
// S_READ while the previous key is written back, and updated in S_WORK.
// A closing S_DONE state sends the last pending word, if any; output stalls
// lengthen a scan.
// Reset is synchronous; a sweep then clears the key memory, one key per cycle.
// A word held on the event port stalls the key walk until it is taken.
module multi_key_debounce_gesture #(
  parameter int KEYS = 16,
  parameter int TIME_BITS = 32
) (
  input wire clk,
  input wire rst,
  mkdg_scan_if.sink scan,
  mkdg_event_if.source events,
  mkdg_cfg_if.sink cfg
);
  localparam int NK = (KEYS < mkdg_pkg::MASK_W) ? KEYS : mkdg_pkg::MASK_W;
  localparam int KW = (NK > 1) ? $clog2(NK) : 1;

  typedef struct packed {
    logic [1:0] db;
    logic [1:0] gs;
    logic prev;
    logic stable;
    logic [7:0] clicks;
    logic [TIME_BITS-1:0] db_start;
    logic [TIME_BITS-1:0] press_start;
    logic [TIME_BITS-1:0] rel_start;
  } key_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_WORK, S_DONE} state_t;

  key_t mem [NK];
  key_t rd;
  key_t wr;
  logic we;
  logic [KW-1:0] k;
  logic [KW-1:0] wk;
  state_t state;
  logic [15:0] regs [mkdg_pkg::NREG];
  logic [TIME_BITS-1:0] time_now;
  logic [15:0] raw;
  logic have_ev;
  logic [3:0] pend_key;
  logic [2:0] pend_code;
  logic [7:0] pend_clicks;
  logic pend_pressed;
  logic out_valid;
  logic out_last;
  logic [3:0] out_key;
  logic [2:0] out_code;
  logic [7:0] out_clicks;
  logic out_pressed;

  // Combinational key update.
  logic [15:0] db_t;
  logic [15:0] mc_t;
  logic lvl;
  logic act;
  logic en;
  logic ev_v;
  logic [2:0] ev;
  key_t nx;

  always_comb begin
    db_t = (regs[mkdg_pkg::REG_DEBOUNCE] != 16'd0) ? regs[mkdg_pkg::REG_DEBOUNCE]
      : mkdg_pkg::DEF_DEBOUNCE;
    mc_t = (regs[mkdg_pkg::REG_MULTI] != 16'd0) ? regs[mkdg_pkg::REG_MULTI]
      : mkdg_pkg::DEF_MULTI;
    lvl = raw[k];
    en = regs[mkdg_pkg::REG_ENABLE][k];
    act = (lvl == regs[mkdg_pkg::REG_LEVEL][k]);
    nx = rd;
    ev_v = 1'b0;
    ev = mkdg_pkg::EV_PRESS;
    unique case (rd.db)
      mkdg_pkg::DB_DOWN, mkdg_pkg::DB_UP: begin
        if ((time_now - rd.db_start) >= TIME_BITS'(db_t)) begin
          if (lvl == rd.prev) begin
            ev_v = 1'b1;
            if (rd.db == mkdg_pkg::DB_DOWN) begin
              nx.stable = 1'b1;
              ev = mkdg_pkg::EV_PRESS;
            end else begin
              nx.stable = 1'b0;
              ev = mkdg_pkg::EV_RELEASE;
            end
          end
          nx.db = mkdg_pkg::DB_IDLE;
        end
      end
      default: begin
        if (act != rd.stable) begin
          nx.db = act ? mkdg_pkg::DB_DOWN : mkdg_pkg::DB_UP;
          nx.db_start = time_now;
        end
      end
    endcase
    nx.prev = lvl;
    unique case (rd.gs)
      mkdg_pkg::GS_IDLE: begin
        if (nx.stable) begin
          nx.gs = mkdg_pkg::GS_PRESSED;
          nx.press_start = time_now;
        end else begin
          nx.clicks = 8'd0;
        end
      end
      mkdg_pkg::GS_PRESSED: begin
        if (nx.stable && (time_now - rd.press_start) >=
            TIME_BITS'(regs[mkdg_pkg::REG_LONG])) begin
          ev_v = 1'b1;
          ev = mkdg_pkg::EV_LONG;
          nx.gs = mkdg_pkg::GS_LONG;
          nx.press_start = time_now;
        end else if (!nx.stable) begin
          nx.clicks = rd.clicks + 8'd1;
          ev_v = 1'b1;
          ev = mkdg_pkg::EV_CLICK;
          nx.gs = mkdg_pkg::GS_WAIT;
          nx.rel_start = time_now;
        end
      end
      mkdg_pkg::GS_WAIT: begin
        if ((time_now - rd.rel_start) >= TIME_BITS'(mc_t)) begin
          nx.gs = mkdg_pkg::GS_IDLE;
        end else if (nx.stable) begin
          nx.gs = mkdg_pkg::GS_PRESSED;
          nx.press_start = time_now;
        end
      end
      default: begin
        if (nx.stable && (time_now - rd.press_start) >=
            TIME_BITS'(regs[mkdg_pkg::REG_REPEAT])) begin
          ev_v = 1'b1;
          ev = mkdg_pkg::EV_CONT;
          nx.press_start = time_now;
        end else if (!nx.stable) begin
          nx.gs = mkdg_pkg::GS_IDLE;
        end
      end
    endcase
    if (!en) begin
      nx = '0;
      ev_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wk] <= wr;
    end
    rd <= mem[k];
  end

  assign scan.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign events.valid = out_valid;
  assign events.key_index = out_key;
  assign events.event_code = out_code;
  assign events.click_total = out_clicks;
  assign events.key_pressed = out_pressed;
  assign events.last_event = out_last;

  logic out_free;
  assign out_free = !out_valid || events.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      k <= '0;
      wk <= '0;
      we <= 1'b0;
      wr <= '0;
      time_now <= '0;
      have_ev <= 1'b0;
      out_valid <= 1'b0;
      regs[0] <= mkdg_pkg::DEF_DEBOUNCE;
      regs[1] <= mkdg_pkg::DEF_MULTI;
      regs[2] <= 16'd1000;
      regs[3] <= 16'd200;
      regs[4] <= 16'd0;
      regs[5] <= 16'd0;
    end else begin
      if (cfg.valid && (int'(cfg.index) < mkdg_pkg::NREG)) begin
        regs[cfg.index] <= cfg.data;
      end
      if (out_valid && events.ready) begin
        out_valid <= 1'b0;
      end
      we <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          we <= 1'b1;
          wr <= '0;
          wk <= k;
          if (int'(k) == NK - 1) begin
            state <= S_IDLE;
            k <= '0;
          end else begin
            k <= k + KW'(1);
          end
        end
        S_IDLE: begin
          if (scan.valid) begin
            raw <= scan.raw_levels;
            time_now <= time_now + TIME_BITS'(scan.elapsed_ticks);
            k <= '0;
            have_ev <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WORK;
        end
        S_WORK: begin
          if (!(ev_v && have_ev) || out_free) begin
            if (ev_v) begin
              if (have_ev) begin
                out_valid <= 1'b1;
                out_last <= 1'b0;
                out_key <= pend_key;
                out_code <= pend_code;
                out_clicks <= pend_clicks;
                out_pressed <= pend_pressed;
              end
              have_ev <= 1'b1;
              pend_key <= 4'(k);
              pend_code <= ev;
              pend_clicks <= nx.clicks;
              pend_pressed <= nx.stable;
            end
            we <= 1'b1;
            wr <= nx;
            wk <= k;
            if (int'(k) == NK - 1) begin
              state <= S_DONE;
            end else begin
              k <= k + KW'(1);
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (!have_ev) begin
            k <= '0;
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            out_last <= 1'b1;
            out_key <= pend_key;
            out_code <= pend_code;
            out_clicks <= pend_clicks;
            out_pressed <= pend_pressed;
            have_ev <= 1'b0;
            k <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0] key;
    mkdg_pkg::ev_code_t code;
    logic [7:0] clicks;
    logic pressed;
    logic last;
  } key_event_t;

  class gesture_scoreboard;
    logic [15:0] debounce_ticks, multi_ticks, long_ticks, repeat_ticks;
    logic [15:0] level_mask, enable_mask;
    logic [31:0] now;
    mkdg_pkg::db_phase_t db_phase[16];
    logic [31:0] db_start[16];
    logic prev_level[16];
    logic stable[16];
    mkdg_pkg::gs_phase_t gs_phase[16];
    logic [31:0] press_at[16];
    logic [31:0] release_at[16];
    logic [7:0] clicks[16];
    key_event_t expected_events[$];
    int errors;

    function new();
      debounce_ticks = 16'd20;
      multi_ticks = 16'd300;
      long_ticks = 16'd1000;
      repeat_ticks = 16'd200;
      level_mask = '0;
      enable_mask = '0;
      now = '0;
      errors = 0;
      for (int k = 0; k < 16; k++) clear_key(k);
    endfunction

    function void clear_key(int k);
      db_phase[k] = mkdg_pkg::DB_IDLE;
      db_start[k] = '0;
      prev_level[k] = 1'b0;
      stable[k] = 1'b0;
      gs_phase[k] = mkdg_pkg::GS_IDLE;
      press_at[k] = '0;
      release_at[k] = '0;
      clicks[k] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        mkdg_pkg::REG_DEBOUNCE: debounce_ticks = data;
        mkdg_pkg::REG_MULTI: multi_ticks = data;
        mkdg_pkg::REG_LONG: long_ticks = data;
        mkdg_pkg::REG_REPEAT: repeat_ticks = data;
        mkdg_pkg::REG_LEVEL: level_mask = data;
        mkdg_pkg::REG_ENABLE: enable_mask = data;
        default: ;
      endcase
    endfunction

    function bit scan_key(int k, logic lvl, output mkdg_pkg::ev_code_t code);
      logic [31:0] db, mc;
      logic act;
      bit hit;
      hit = 0;
      code = mkdg_pkg::EV_PRESS;
      db = (debounce_ticks != 0) ? {16'd0, debounce_ticks}
        : {16'd0, mkdg_pkg::DEF_DEBOUNCE};
      mc = (multi_ticks != 0) ? {16'd0, multi_ticks} : {16'd0, mkdg_pkg::DEF_MULTI};
      act = (lvl == level_mask[k]);
      if (db_phase[k] == mkdg_pkg::DB_DOWN || db_phase[k] == mkdg_pkg::DB_UP) begin
        if (now - db_start[k] >= db) begin
          if (lvl == prev_level[k]) begin
            hit = 1;
            if (db_phase[k] == mkdg_pkg::DB_DOWN) begin
              stable[k] = 1'b1;
              code = mkdg_pkg::EV_PRESS;
            end else begin
              stable[k] = 1'b0;
              code = mkdg_pkg::EV_RELEASE;
            end
          end
          db_phase[k] = mkdg_pkg::DB_IDLE;
        end
      end else if (act != stable[k]) begin
        db_phase[k] = act ? mkdg_pkg::DB_DOWN : mkdg_pkg::DB_UP;
        db_start[k] = now;
      end
      prev_level[k] = lvl;
      case (gs_phase[k])
        mkdg_pkg::GS_IDLE: begin
          if (stable[k]) begin
            gs_phase[k] = mkdg_pkg::GS_PRESSED;
            press_at[k] = now;
          end else begin
            clicks[k] = '0;
          end
        end
        mkdg_pkg::GS_PRESSED: begin
          if (stable[k] && now - press_at[k] >= {16'd0, long_ticks}) begin
            hit = 1;
            code = mkdg_pkg::EV_LONG;
            gs_phase[k] = mkdg_pkg::GS_LONG;
            press_at[k] = now;
          end else if (!stable[k]) begin
            clicks[k] = clicks[k] + 8'd1;
            hit = 1;
            code = mkdg_pkg::EV_CLICK;
            gs_phase[k] = mkdg_pkg::GS_WAIT;
            release_at[k] = now;
          end
        end
        mkdg_pkg::GS_WAIT: begin
          if (now - release_at[k] >= mc) begin
            gs_phase[k] = mkdg_pkg::GS_IDLE;
          end else if (stable[k]) begin
            gs_phase[k] = mkdg_pkg::GS_PRESSED;
            press_at[k] = now;
          end
        end
        default: begin
          if (stable[k] && now - press_at[k] >= {16'd0, repeat_ticks}) begin
            hit = 1;
            code = mkdg_pkg::EV_CONT;
            press_at[k] = now;
          end else if (!stable[k]) begin
            gs_phase[k] = mkdg_pkg::GS_IDLE;
          end
        end
      endcase
      return hit;
    endfunction

    function void note_scan(logic [15:0] raw, logic [7:0] elapsed);
      key_event_t e;
      mkdg_pkg::ev_code_t code;
      int n;
      n = 0;
      now = now + {24'd0, elapsed};
      for (int k = 0; k < 16; k++) begin
        if (!enable_mask[k]) begin
          clear_key(k);
        end else if (scan_key(k, raw[k], code)) begin
          e.key = k[3:0];
          e.code = code;
          e.clicks = clicks[k];
          e.pressed = stable[k];
          e.last = 1'b0;
          expected_events.push_back(e);
          n++;
        end
      end
      if (n > 0) expected_events[$].last = 1'b1;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_event(key_event_t got);
      key_event_t e;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected word key %0d code %0d", got.key, got.code));
      end else begin
        e = expected_events.pop_front();
        if (got.key !== e.key)
          report($sformatf("key_index %0d, want %0d", got.key, e.key));
        if (got.code !== e.code)
          report($sformatf("key %0d event_code %0d, want %0d", e.key, got.code, e.code));
        if (got.clicks !== e.clicks)
          report($sformatf("key %0d click_total %0d, want %0d", e.key, got.clicks,
            e.clicks));
        if (got.pressed !== e.pressed)
          report($sformatf("key %0d key_pressed %b, want %b", e.key, got.pressed, e.pressed));
        if (got.last !== e.last)
          report($sformatf("key %0d last_event %b, want %b", e.key, got.last, e.last));
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 5000;

  logic clk, rst;
  mkdg_scan_if scan_ch();
  mkdg_event_if ev_ch();
  mkdg_cfg_if cfg_ch();

  multi_key_debounce_gesture dut (
    .clk(clk), .rst(rst), .scan(scan_ch), .events(ev_ch), .cfg(cfg_ch)
  );

  gesture_scoreboard sb = new();
  bit quiet;
  int hold_left, gap_left, stall_cycles;
  logic [15:0] key_target;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      ev_ch.ready = 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      ev_ch.ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(1, 10) - 1;
      ev_ch.ready = 1'b0;
    end else begin
      ev_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    key_event_t got;
    if (!rst) begin
      if (ev_ch.valid && ev_ch.ready) begin
        got.key = ev_ch.key_index;
        got.code = mkdg_pkg::ev_code_t'(ev_ch.event_code);
        got.clicks = ev_ch.click_total;
        got.pressed = ev_ch.key_pressed;
        got.last = ev_ch.last_event;
        sb.check_event(got);
      end
      if ((ev_ch.valid && ev_ch.ready) || (scan_ch.valid && scan_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(logic [15:0] deb, logic [15:0] multi, logic [15:0] lng,
                           logic [15:0] rep, logic [15:0] lvl, logic [15:0] en);
    cfg_write(mkdg_pkg::REG_DEBOUNCE, deb);
    cfg_write(mkdg_pkg::REG_MULTI, multi);
    cfg_write(mkdg_pkg::REG_LONG, lng);
    cfg_write(mkdg_pkg::REG_REPEAT, rep);
    cfg_write(mkdg_pkg::REG_LEVEL, lvl);
    cfg_write(mkdg_pkg::REG_ENABLE, en);
  endtask

  // Scan words are offered back to back; valid drops only for a random idle burst or in drain.
  task automatic send_scan(logic [15:0] raw, logic [7:0] elapsed);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      scan_ch.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    scan_ch.valid = 1'b1;
    scan_ch.raw_levels = raw;
    scan_ch.elapsed_ticks = elapsed;
    do @(posedge clk); while (!scan_ch.ready);
    sb.note_scan(raw, elapsed);
    @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    scan_ch.valid = 1'b0;
    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Keys follow a slowly changing target level; some scans carry glitches.
  task automatic random_scans(int count, int max_elapsed);
    logic [15:0] raw;
    logic [7:0] elapsed;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 16; k++)
        if ($urandom_range(0, 9) == 0) key_target[k] = ~key_target[k];
      raw = key_target;
      if ($urandom_range(0, 6) == 0) raw = raw ^ 16'($urandom);
      elapsed = ($urandom_range(0, 19) == 0) ? 8'($urandom)
        : 8'($urandom_range(0, max_elapsed));
      send_scan(raw, elapsed);
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    hold_left = 0;
    gap_left = 0;
    stall_cycles = 0;
    key_target = '0;
    scan_ch.valid = 1'b0;
    scan_ch.raw_levels = '0;
    scan_ch.elapsed_ticks = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset timings unused, ignored register index, full press cycle.
    cfg_write(3'd7, 16'hFFFF);
    cfg_write(3'd6, 16'h1234);
    configure(16'd2, 16'd20, 16'd30, 16'd10, 16'h00FF, 16'hFFFF);
    send_scan(16'h00FF, 8'd0);
    send_scan(16'h00FF, 8'd3);
    send_scan(16'h00FF, 8'd10);
    send_scan(16'h00FF, 8'd10);
    send_scan(16'h00FF, 8'd10);
    send_scan(16'h00FF, 8'd10);
    send_scan(16'hFF00, 8'd1);
    send_scan(16'hFF00, 8'd3);
    send_scan(16'h00FF, 8'd1);
    send_scan(16'h00FF, 8'd3);
    send_scan(16'hFF00, 8'd1);
    send_scan(16'hFF00, 8'd3);
    send_scan(16'h00FF, 8'd1);
    send_scan(16'h00FF, 8'd3);
    send_scan(16'hFF00, 8'd1);
    send_scan(16'hFF00, 8'd3);
    send_scan(16'h0F0F, 8'd1);
    send_scan(16'hF0F0, 8'd3);
    send_scan(16'hFF00, 8'd255);
    send_scan(16'hFF00, 8'd255);
    send_scan(16'h5555, 8'd0);
    send_scan(16'hAAAA, 8'd255);
    drain();

    configure(16'd5, 16'd40, 16'd60, 16'd15, 16'($urandom), 16'hFFFF);
    hold_left = 400;
    random_scans(70, 8);
    drain();

    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'hA5A5, 16'hFFFF);
    random_scans(70, 12);
    drain();

    configure(16'd1, 16'd1, 16'd30, 16'd0, 16'hFFFF, 16'($urandom));
    random_scans(70, 6);
    drain();

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    random_scans(30, 255);
    drain();

    configure(16'd10, 16'd100, 16'd120, 16'd40, 16'($urandom), 16'hFFFF);
    quiet = 1'b1;
    random_scans(80, 10);
    drain();

    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/mkdg_pkg.sv
rtl/mkdg_scan_if.sv
rtl/mkdg_event_if.sv
rtl/mkdg_cfg_if.sv
rtl/multi_key_debounce_gesture.sv
tb/sv/tb.sv
